[hdl/assert_macros.svh]
// Assertion macros shared by the checker files of the tare and weigh block.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is high.
`define LCTW_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check, live through reset too.
`define LCTW_ASSERT(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/lctw_pkg.sv]
// Shared widths, register codes, reset values and the config struct of the
// tare and weigh block. Depends on nothing.
`default_nettype none
package lctw_pkg;

   localparam int RAW_W          = 24;
   localparam int FRAC_W         = 8;
   localparam int WDIV_W         = RAW_W + FRAC_W;
   localparam int WEIGHT_W       = 20;
   localparam int SCALE_W        = 16;
   localparam int LIMIT_W        = 8;
   localparam int BUCKET_KEEP_W  = 15;
   localparam int BUCKET_SIZE_DEF = 1000;

   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;

   localparam logic REG_SCALE_Q8   = 1'b0;
   localparam logic REG_IDLE_LIMIT = 1'b1;

   localparam logic [SCALE_W-1:0] SCALE_RESET      = 16'd17920;
   localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RESET = 8'd200;
   localparam logic [LIMIT_W-1:0] IDLE_COUNT_MAX   = 8'd255;

   localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = 20'sh7FFFF;
   localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = 20'sh80000;
   localparam logic [WDIV_W-1:0] WEIGHT_POS_LIM = WDIV_W'(524287);
   localparam logic [WDIV_W-1:0] WEIGHT_NEG_LIM = WDIV_W'(524288);

   typedef struct packed {
      logic [SCALE_W-1:0] scale_q8;
      logic [LIMIT_W-1:0] idle_limit;
   } cfg_type;

endpackage
`default_nettype wire

[hdl/load_cell_tare_weigh_core.sv]
// Load-cell tare and weigh core: top level.
// Depends on lctw_pkg, lctw_csr and lctw_serial_div.
//
// Input channel req_*: one averaged signed 24-bit count per word, plus a
// tare request that retakes the tare on the sample after this one. Result
// channel rsp_*: exactly one word per input word, in order: net weight in
// grams, weight_shown, tare_taken and sleep_request.
// Each word runs through two bit-serial dividers side by side: a 32-step
// one for (raw - tare) * 256 / scale_q8 and a 24-step one for the idle
// bucket raw / BUCKET_SIZE. The 32-step divider sets the pace: req_ready
// returns as the result shows, so no word is taken while one is being divided.
// The result sits in an output register; while it waits, the next word is
// accepted and computed. A finished result that finds the output register
// still full holds until rsp_ready frees it, and no new word is taken.
// Reset (synchronous) clears the tare, the first-sample flag, the idle
// bucket and count, and loads the register defaults (scale 70.0, limit 200).
// Registers scale_q8 (byte 0) and idle_limit (byte 4) sit on the APB port.
`default_nettype none
module load_cell_tare_weigh_core #(
   parameter int BUCKET_SIZE = lctw_pkg::BUCKET_SIZE_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic signed [lctw_pkg::RAW_W-1:0]      req_raw_count,
   input  wire logic                                   req_tare_request,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed      [lctw_pkg::WEIGHT_W-1:0]   rsp_weight,
   output logic                                        rsp_weight_shown,
   output logic                                        rsp_tare_taken,
   output logic                                        rsp_sleep_request,
   input  wire logic                                   psel,
   input  wire logic                                   penable,
   input  wire logic                                   pwrite,
   input  wire logic        [lctw_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic        [lctw_pkg::CSR_DATA_W-1:0] pwdata,
   output logic             [lctw_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                        pready
);

   localparam int RAW_W    = lctw_pkg::RAW_W;
   localparam int WDIV_W   = lctw_pkg::WDIV_W;
   localparam int WEIGHT_W = lctw_pkg::WEIGHT_W;
   localparam int KEEP_W   = lctw_pkg::BUCKET_KEEP_W;
   localparam int BDIV_W   = $clog2(BUCKET_SIZE + 1);
   localparam logic [BDIV_W-1:0] BUCKET_DIV = BDIV_W'(BUCKET_SIZE);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   lctw_pkg::cfg_type cfg;

   state_type                   state_ff, state_in;
   logic                        first_done_ff, first_done_in;
   logic                        tare_valid_ff, tare_valid_in;
   logic signed [RAW_W-1:0]     tare_value_ff, tare_value_in;
   logic [KEEP_W-1:0]           prev_bucket_ff, prev_bucket_in;
   logic [lctw_pkg::LIMIT_W-1:0] idle_count_ff, idle_count_in;
   logic                        wdone_ff, wdone_in;
   logic                        bdone_ff, bdone_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic signed [RAW_W-1:0]     raw_ff;
   logic                        treq_ff;
   logic                        raw_neg_ff;
   logic                        diff_neg_ff;
   logic                        diff_zero_ff;
   logic                        shown_ff;
   logic                        taken_ff;
   logic                        discard_ff;
   logic signed [WEIGHT_W-1:0]  rsp_weight_ff, rsp_weight_in;
   logic                        rsp_shown_ff;
   logic                        rsp_taken_ff;
   logic                        rsp_sleep_ff, rsp_sleep_in;

   logic                        accept;
   logic                        all_done;
   logic                        out_free;
   logic                        finish;
   logic signed [RAW_W:0]       diff;
   logic [RAW_W-1:0]            diff_mag;
   logic [RAW_W-1:0]            raw_mag;
   logic                        w_done;
   logic [WDIV_W-1:0]           w_quot;
   logic                        b_done;
   logic [RAW_W-1:0]            b_quot;
   logic [KEEP_W-1:0]           bucket;
   logic                        same_bucket;
   logic [lctw_pkg::LIMIT_W-1:0] count_inc;

   lctw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign diff      = {req_raw_count[RAW_W-1], req_raw_count}
                    - {tare_value_ff[RAW_W-1], tare_value_ff};
   assign diff_mag  = diff[RAW_W] ? RAW_W'(-diff) : diff[RAW_W-1:0];
   assign raw_mag   = req_raw_count[RAW_W-1] ? RAW_W'(-req_raw_count)
                                             : req_raw_count;

   lctw_serial_div #(
      .DIVIDEND_W (WDIV_W),
      .DIVISOR_W  (lctw_pkg::SCALE_W)
   ) u_wdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend ({diff_mag, {lctw_pkg::FRAC_W{1'b0}}}),
      .divisor  (cfg.scale_q8),
      .done     (w_done),
      .quotient (w_quot)
   );

   lctw_serial_div #(
      .DIVIDEND_W (RAW_W),
      .DIVISOR_W  (BDIV_W)
   ) u_bdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend (raw_mag),
      .divisor  (BUCKET_DIV),
      .done     (b_done),
      .quotient (b_quot)
   );

   assign all_done    = (wdone_ff || w_done) && (bdone_ff || b_done);
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign finish      = ((state_ff == ST_RUN && all_done) || state_ff == ST_HOLD)
                        && out_free;
   assign bucket      = raw_neg_ff ? KEEP_W'(-b_quot[KEEP_W-1:0]) : b_quot[KEEP_W-1:0];
   assign same_bucket = (bucket == prev_bucket_ff);
   assign count_inc   = (idle_count_ff == lctw_pkg::IDLE_COUNT_MAX) ? idle_count_ff
                                                                    : idle_count_ff + 1'b1;

   always_comb begin
      case (state_ff)
         ST_IDLE: state_in = accept ? ST_RUN : ST_IDLE;
         ST_RUN: begin
            if (all_done) state_in = out_free ? ST_IDLE : ST_HOLD;
            else          state_in = ST_RUN;
         end
         ST_HOLD: state_in = out_free ? ST_IDLE : ST_HOLD;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (!shown_ff) begin
         rsp_weight_in = '0;
      end else if (cfg.scale_q8 == '0) begin
         if (diff_zero_ff)     rsp_weight_in = '0;
         else if (diff_neg_ff) rsp_weight_in = lctw_pkg::WEIGHT_MIN;
         else                  rsp_weight_in = lctw_pkg::WEIGHT_MAX;
      end else if (!diff_neg_ff) begin
         rsp_weight_in = (w_quot > lctw_pkg::WEIGHT_POS_LIM) ? lctw_pkg::WEIGHT_MAX
                                                              : w_quot[WEIGHT_W-1:0];
      end else begin
         rsp_weight_in = (w_quot > lctw_pkg::WEIGHT_NEG_LIM) ? lctw_pkg::WEIGHT_MIN
                                                              : -w_quot[WEIGHT_W-1:0];
      end
   end

   always_comb begin
      first_done_in  = first_done_ff;
      tare_valid_in  = tare_valid_ff;
      tare_value_in  = tare_value_ff;
      prev_bucket_in = prev_bucket_ff;
      idle_count_in  = idle_count_ff;
      rsp_sleep_in   = 1'b0;
      if (finish) begin
         if (discard_ff) begin
            first_done_in = 1'b1;
         end else begin
            if (taken_ff) begin
               tare_value_in = raw_ff;
               tare_valid_in = 1'b1;
            end
            if (treq_ff) tare_valid_in = 1'b0;
            if (!same_bucket) begin
               prev_bucket_in = bucket;
               idle_count_in  = '0;
            end else begin
               idle_count_in = count_inc;
               rsp_sleep_in  = (count_inc >= cfg.idle_limit);
            end
         end
      end
   end

   always_comb begin
      wdone_in = wdone_ff || w_done;
      bdone_in = bdone_ff || b_done;
      if (accept) begin
         wdone_in = 1'b0;
         bdone_in = 1'b0;
      end
      if (finish)         rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else                rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         first_done_ff  <= 1'b0;
         tare_valid_ff  <= 1'b0;
         tare_value_ff  <= '0;
         prev_bucket_ff <= '0;
         idle_count_ff  <= '0;
         wdone_ff       <= 1'b0;
         bdone_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         first_done_ff  <= first_done_in;
         tare_valid_ff  <= tare_valid_in;
         tare_value_ff  <= tare_value_in;
         prev_bucket_ff <= prev_bucket_in;
         idle_count_ff  <= idle_count_in;
         wdone_ff       <= wdone_in;
         bdone_ff       <= bdone_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         raw_ff       <= req_raw_count;
         treq_ff      <= req_tare_request;
         raw_neg_ff   <= req_raw_count[RAW_W-1];
         diff_neg_ff  <= diff[RAW_W];
         diff_zero_ff <= (diff == '0);
         discard_ff   <= !first_done_ff;
         shown_ff     <= first_done_ff && tare_valid_ff;
         taken_ff     <= first_done_ff && !tare_valid_ff;
      end
      if (finish) begin
         rsp_weight_ff <= rsp_weight_in;
         rsp_shown_ff  <= shown_ff;
         rsp_taken_ff  <= taken_ff;
         rsp_sleep_ff  <= rsp_sleep_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_weight        = rsp_weight_ff;
   assign rsp_weight_shown  = rsp_shown_ff;
   assign rsp_tare_taken    = rsp_taken_ff;
   assign rsp_sleep_request = rsp_sleep_ff;

endmodule
`default_nettype wire

[hdl/lctw_csr.sv]
// APB-style register file holding scale_q8 and idle_limit.
// Depends on lctw_pkg.
`default_nettype none
module lctw_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [lctw_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [lctw_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [lctw_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                   pready,
   output lctw_pkg::cfg_type                      cfg
);

   lctw_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_en;
   logic              reg_idx;

   assign reg_idx = paddr[2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            lctw_pkg::REG_SCALE_Q8:   cfg_in.scale_q8   = pwdata[lctw_pkg::SCALE_W-1:0];
            lctw_pkg::REG_IDLE_LIMIT: cfg_in.idle_limit = pwdata[lctw_pkg::LIMIT_W-1:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         lctw_pkg::REG_SCALE_Q8:
            prdata = lctw_pkg::CSR_DATA_W'(cfg_ff.scale_q8);
         lctw_pkg::REG_IDLE_LIMIT:
            prdata = lctw_pkg::CSR_DATA_W'(cfg_ff.idle_limit);
         default:
            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale_q8   <= lctw_pkg::SCALE_RESET;
         cfg_ff.idle_limit <= lctw_pkg::IDLE_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

[hdl/lctw_serial_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// Dividend shifts out of a register while quotient bits shift in. No deps.
`default_nettype none
module lctw_serial_div #(
   parameter int DIVIDEND_W = 32,
   parameter int DIVISOR_W  = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       done,
   output logic      [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] dq_ff, dq_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;

   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    trial_sub;
   logic                  fits;

   assign trial     = {rem_ff, dq_ff[DIVIDEND_W-1]};
   assign trial_sub = trial - {1'b0, dvs_ff};
   assign fits      = trial >= {1'b0, dvs_ff};
   assign done      = done_ff;
   assign quotient  = dq_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dq_in   = dq_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dq_in   = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         dq_in  = {dq_ff[DIVIDEND_W-2:0], fits};
         rem_in = fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      dvs_ff <= dvs_in;
   end

endmodule
`default_nettype wire

[hdl/lctw_checker.sv]
// Port-level checks for load_cell_tare_weigh_core, bound to the top level.
// Depends on assert_macros.svh and lctw_pkg.
`default_nettype none
`include "assert_macros.svh"
module lctw_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_valid,
   input wire logic                                 req_ready,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_ready,
   input wire logic signed [lctw_pkg::WEIGHT_W-1:0] rsp_weight,
   input wire logic                                 rsp_weight_shown,
   input wire logic                                 rsp_tare_taken
);

   `LCTW_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp word dropped while stalled")
   `LCTW_ASSERT_RST(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready, "new word taken while busy")
   `LCTW_ASSERT_RST(a_weight_zero, clock, reset, rsp_valid && !rsp_weight_shown |-> rsp_weight == '0, "weight not zero when hidden")
   `LCTW_ASSERT_RST(a_shown_taken, clock, reset, rsp_valid |-> !(rsp_weight_shown && rsp_tare_taken), "weight and tare on one word")
   `LCTW_ASSERT(a_reset_clear, clock, reset |=> !rsp_valid && req_ready, "reset leaves word pending")

endmodule

bind load_cell_tare_weigh_core lctw_checker u_lctw_checker (.*);
`default_nettype wire

[test/lctw_weigh_checker.sv]
`timescale 1ns / 1ps
// Checker for the load-cell tare and weigh core: watches the sample, result and
// register ports, predicts every result word and compares it field by field.
// Depends on lctw_pkg.
module lctw_weigh_checker #(
   parameter int BUCKET_SIZE = lctw_pkg::BUCKET_SIZE_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   input  wire logic                                   req_ready,
   input  wire logic signed [lctw_pkg::RAW_W-1:0]      req_raw_count,
   input  wire logic                                   req_tare_request,
   input  wire logic                                   rsp_valid,
   input  wire logic                                   rsp_ready,
   input  wire logic signed [lctw_pkg::WEIGHT_W-1:0]   rsp_weight,
   input  wire logic                                   rsp_weight_shown,
   input  wire logic                                   rsp_tare_taken,
   input  wire logic                                   rsp_sleep_request,
   input  wire logic                                   psel,
   input  wire logic                                   penable,
   input  wire logic                                   pwrite,
   input  wire logic        [lctw_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic        [lctw_pkg::CSR_DATA_W-1:0] pwdata,
   input  wire logic                                   pready,
   output int                                          error_count,
   output int                                          pending_count,
   output int                                          checked_count
);

   localparam int RAW_W      = lctw_pkg::RAW_W;
   localparam int WEIGHT_W   = lctw_pkg::WEIGHT_W;
   localparam int KEEP_W     = lctw_pkg::BUCKET_KEEP_W;
   localparam int LIMIT_W    = lctw_pkg::LIMIT_W;
   localparam int SCALE_W    = lctw_pkg::SCALE_W;
   localparam int CSR_ADDR_W = lctw_pkg::CSR_ADDR_W;
   localparam logic [CSR_ADDR_W-1:0] SCALE_ADDR = CSR_ADDR_W'(4 * lctw_pkg::REG_SCALE_Q8);
   localparam logic [CSR_ADDR_W-1:0] LIMIT_ADDR = CSR_ADDR_W'(4 * lctw_pkg::REG_IDLE_LIMIT);

   typedef struct packed {
      logic signed [WEIGHT_W-1:0] weight;
      logic                       shown;
      logic                       taken;
      logic                       sleep;
   } weighing_type;

   lctw_pkg::cfg_type          shadow_cfg;
   bit                         first_done;
   bit                         tare_held;
   logic signed [RAW_W-1:0]    tare_value;
   logic [KEEP_W-1:0]          prev_bucket;
   logic [LIMIT_W-1:0]         idle_count;
   weighing_type               expected_weighings[$];
   int                         mismatches;
   int                         waiting;
   int                         checked;

   assign error_count   = mismatches;
   assign pending_count = waiting;
   assign checked_count = checked;

   initial begin
      mismatches = 0;
      waiting    = 0;
      checked    = 0;
   end

   function automatic weighing_type predict_weighing(input logic signed [RAW_W-1:0] raw,
                                                     input logic tare_req);
      weighing_type             r;
      longint                   diff;
      longint                   quo;
      logic [KEEP_W-1:0]        bucket;
      r = '0;
      if (!first_done) begin
         first_done = 1'b1;
         return r;
      end
      if (tare_held) begin
         diff = longint'(raw) - longint'(tare_value);
         if (shadow_cfg.scale_q8 == '0) begin
            quo = (diff > 0) ? longint'(lctw_pkg::WEIGHT_MAX)
                : (diff < 0) ? longint'(lctw_pkg::WEIGHT_MIN) : 0;
         end else begin
            quo = (diff * 256) / longint'(shadow_cfg.scale_q8);
            if (quo > longint'(lctw_pkg::WEIGHT_MAX)) quo = longint'(lctw_pkg::WEIGHT_MAX);
            if (quo < longint'(lctw_pkg::WEIGHT_MIN)) quo = longint'(lctw_pkg::WEIGHT_MIN);
         end
         r.weight = WEIGHT_W'(quo);
         r.shown  = 1'b1;
      end else begin
         tare_value = raw;
         tare_held  = 1'b1;
         r.taken    = 1'b1;
      end
      if (tare_req) tare_held = 1'b0;
      bucket = KEEP_W'(longint'(raw) / longint'(BUCKET_SIZE));
      if (bucket != prev_bucket) begin
         prev_bucket = bucket;
         idle_count  = '0;
      end else begin
         if (idle_count < lctw_pkg::IDLE_COUNT_MAX) idle_count = idle_count + 1'b1;
         r.sleep = (idle_count >= shadow_cfg.idle_limit);
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatches++;
      $display("checker: %s mismatch on result %0d: got %0d, expected %0d",
               what, checked, got, want);
   endtask

   always @(posedge clock) begin
      weighing_type want;
      if (reset) begin
         shadow_cfg.scale_q8   = lctw_pkg::SCALE_RESET;
         shadow_cfg.idle_limit = lctw_pkg::IDLE_LIMIT_RESET;
         first_done            = 1'b0;
         tare_held             = 1'b0;
         tare_value            = '0;
         prev_bucket           = '0;
         idle_count            = '0;
         expected_weighings.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == SCALE_ADDR) shadow_cfg.scale_q8 = pwdata[SCALE_W-1:0];
            else if (paddr == LIMIT_ADDR) shadow_cfg.idle_limit = pwdata[LIMIT_W-1:0];
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_weighings.size() == 0) begin
               report_mismatch("unexpected word", 1, 0);
            end else begin
               want = expected_weighings.pop_front();
               if (rsp_weight !== want.weight)
                  report_mismatch("weight", rsp_weight, want.weight);
               if (rsp_weight_shown !== want.shown)
                  report_mismatch("weight_shown", rsp_weight_shown, want.shown);
               if (rsp_tare_taken !== want.taken)
                  report_mismatch("tare_taken", rsp_tare_taken, want.taken);
               if (rsp_sleep_request !== want.sleep)
                  report_mismatch("sleep_request", rsp_sleep_request, want.sleep);
               checked++;
            end
         end
         if (req_valid && req_ready)
            expected_weighings.push_back(predict_weighing(req_raw_count, req_tare_request));
      end
      waiting = expected_weighings.size();
   end

endmodule

[test/load_cell_tare_weigh_core_tb.sv]
`timescale 1ns / 1ps
// Testbench top for load_cell_tare_weigh_core: drives samples, register writes and
// result back-pressure, and takes the verdict from the checker's mismatch count.
// Depends on lctw_pkg, load_cell_tare_weigh_core and lctw_weigh_checker.
module load_cell_tare_weigh_core_tb;

   localparam int BUCKET_SIZE     = lctw_pkg::BUCKET_SIZE_DEF;
   localparam int RAW_W           = lctw_pkg::RAW_W;
   localparam int WEIGHT_W        = lctw_pkg::WEIGHT_W;
   localparam int SCALE_W         = lctw_pkg::SCALE_W;
   localparam int LIMIT_W         = lctw_pkg::LIMIT_W;
   localparam int CSR_ADDR_W      = lctw_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W      = lctw_pkg::CSR_DATA_W;
   localparam int IDLE_PCT        = 22;
   localparam int DRAIN_CYCLES    = 40;
   localparam int HOLD_OFF_CYCLES = 500;
   localparam int CYCLE_LIMIT     = 400000;
   localparam logic [CSR_ADDR_W-1:0] SCALE_ADDR = CSR_ADDR_W'(4 * lctw_pkg::REG_SCALE_Q8);
   localparam logic [CSR_ADDR_W-1:0] LIMIT_ADDR = CSR_ADDR_W'(4 * lctw_pkg::REG_IDLE_LIMIT);
   localparam int RAW_HI = 8388607;
   localparam int RAW_LO = -8388608;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic signed [RAW_W-1:0]      req_raw_count;
   logic                         req_tare_request;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic signed [WEIGHT_W-1:0]   rsp_weight;
   logic                         rsp_weight_shown;
   logic                         rsp_tare_taken;
   logic                         rsp_sleep_request;
   logic                         psel;
   logic                         penable;
   logic                         pwrite;
   logic [CSR_ADDR_W-1:0]        paddr;
   logic [CSR_DATA_W-1:0]        pwdata;
   logic [CSR_DATA_W-1:0]        prdata;
   logic                         pready;

   int error_count;
   int pending_count;
   int checked_count;
   int cycle_count = 0;
   int samples_sent = 0;
   int settings_applied = 0;
   int rx_hold_left = 0;
   bit steady_flow = 1'b0;

   load_cell_tare_weigh_core #(.BUCKET_SIZE(BUCKET_SIZE)) i_dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_raw_count, .req_tare_request,
      .rsp_valid, .rsp_ready, .rsp_weight, .rsp_weight_shown, .rsp_tare_taken,
      .rsp_sleep_request,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   lctw_weigh_checker #(.BUCKET_SIZE(BUCKET_SIZE)) i_checker (
      .clock, .reset,
      .req_valid, .req_ready, .req_raw_count, .req_tare_request,
      .rsp_valid, .rsp_ready, .rsp_weight, .rsp_weight_shown, .rsp_tare_taken,
      .rsp_sleep_request,
      .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
      .error_count, .pending_count, .checked_count
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold_left > 0) begin
            rsp_ready    = 1'b0;
            rx_hold_left = rx_hold_left - 1;
         end else begin
            rsp_ready = steady_flow || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   task automatic send_sample(input int raw, input bit tare);
      @(negedge clock);
      while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid        = 1'b1;
      req_raw_count    = RAW_W'(raw);
      req_tare_request = tare;
      do @(posedge clock); while (!req_ready);
      samples_sent++;
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = addr;
      pwdata  = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [SCALE_W-1:0] scale, input logic [LIMIT_W-1:0] limit);
      @(negedge clock);
      req_valid = 1'b0;
      wait_drained();
      csr_write(SCALE_ADDR, CSR_DATA_W'(scale));
      csr_write(LIMIT_ADDR, CSR_DATA_W'(limit));
      settings_applied++;
      @(posedge clock);
   endtask

   task automatic run_phase(input logic [SCALE_W-1:0] scale, input logic [LIMIT_W-1:0] limit,
                            input int count, input int hold_off, input bit steady);
      int sent;
      int kind;
      int len;
      int mag_base;
      int mag;
      int raw;
      bit negative;
      apply_settings(scale, limit);
      steady_flow  = steady;
      rx_hold_left = hold_off;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(99);
         if (kind < 55) begin
            len      = $urandom_range(int'(limit) + 12, 1);
            mag_base = $urandom_range(8387) * 1000;
            negative = 1'($urandom_range(1));
            for (int k = 0; k < len; k++) begin
               mag = mag_base + 100 + $urandom_range(800);
               send_sample(negative ? -mag : mag, $urandom_range(99) < 4);
            end
         end else if (kind < 85) begin
            len = $urandom_range(6, 1);
            for (int k = 0; k < len; k++)
               send_sample(int'($urandom), $urandom_range(99) < 15);
         end else begin
            len = $urandom_range(3, 1);
            for (int k = 0; k < len; k++) begin
               case ($urandom_range(7))
                  0: raw = RAW_HI;
                  1: raw = RAW_LO;
                  2: raw = 0;
                  3: raw = -1;
                  4: raw = 999;
                  5: raw = -999;
                  6: raw = 1000;
                  default: raw = -1000;
               endcase
               send_sample(raw, $urandom_range(99) < 10);
            end
         end
         sent += len;
      end
      @(negedge clock);
      req_valid   = 1'b0;
      wait_drained();
      steady_flow = 1'b0;
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_raw_count    = '0;
      req_tare_request = 1'b0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset defaults: dropped first sample, tare, extremes, tare retake
      send_sample(RAW_HI, 1'b1);
      send_sample(0, 1'b0);
      send_sample(RAW_HI, 1'b0);
      send_sample(RAW_LO, 1'b0);
      send_sample(999, 1'b0);
      send_sample(-999, 1'b0);
      send_sample(0, 1'b1);
      send_sample(-1, 1'b0);
      send_sample(1000, 1'b0);

      // zero scale and zero idle limit
      apply_settings(16'd0, 8'd0);
      send_sample(5, 1'b0);
      send_sample(-1, 1'b0);
      send_sample(-2, 1'b0);
      send_sample(RAW_LO, 1'b1);
      send_sample(100, 1'b0);

      // smallest scale: saturate both ways
      apply_settings(16'd1, 8'd1);
      send_sample(RAW_HI, 1'b0);
      send_sample(RAW_LO, 1'b0);
      send_sample(101, 1'b0);
      send_sample(99, 1'b0);

      // largest scale and idle limit
      apply_settings(16'hFFFF, 8'hFF);
      send_sample(RAW_HI, 1'b0);
      send_sample(RAW_LO, 1'b0);
      send_sample(RAW_LO, 1'b0);

      run_phase(16'd17920, 8'd200, 250, 0, 1'b0);
      run_phase(16'd8960, 8'd1, 200, 0, 1'b0);
      run_phase(16'd64000, 8'd255, 350, 0, 1'b0);
      run_phase(16'd256, 8'd3, 150, HOLD_OFF_CYCLES, 1'b0);
      run_phase(16'd0, 8'd0, 120, 0, 1'b0);
      run_phase(16'hFFFF, 8'd20, 150, 0, 1'b1);
      run_phase(16'd1, 8'd10, 150, 0, 1'b0);
      run_phase(SCALE_W'($urandom_range(64000, 8960)), LIMIT_W'($urandom_range(255, 1)),
                130, 0, 1'b0);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("tb: %0d samples over %0d register settings (zero, unit and full scale,",
               samples_sent, settings_applied);
      $display("tb: idle limits 0 to 255, tare retakes, stalls); %0d results checked",
               checked_count);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

[files.f]
+incdir+hdl
hdl/lctw_pkg.sv
hdl/lctw_csr.sv
hdl/lctw_serial_div.sv
hdl/load_cell_tare_weigh_core.sv
hdl/lctw_checker.sv
test/lctw_weigh_checker.sv
test/load_cell_tare_weigh_core_tb.sv
